@@ hdl/sse_pkg.sv @@
// ----------------------------------------------------------------------------
// sse_pkg: shared types and constants of the strand sort engine
// Holds the capacity, index widths, the item and result payloads, and the
// command and status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1) > 0 ? $clog2(MAX_ITEMS + 1) : 1;
  localparam int MRG_DEPTH = 2 ** (IDX_W + 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     is_last;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     overflow;
  } result_t;

  typedef struct packed {
    logic store_in;
    logic sort_init;
    logic scan_init;
    logic scan_skip;
    logic scan_read;
    logic scan_eval;
    logic merge_init;
    logic merge_read;
    logic merge_eval;
    logic merge_done;
    logic out_init;
    logic out_read;
    logic out_load;
    logic finish;
  } sse_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic scan_taken;
    logic remaining_zero;
    logic merge_end;
    logic out_last;
    logic out_free;
  } sse_sts_t;

endpackage

@@ hdl/strand_sort_engine.sv @@
// ----------------------------------------------------------------------------
// strand_sort_engine: collects a set of signed values and emits it sorted
// Top level: joins the sequencing controller and the storage datapath.
// ----------------------------------------------------------------------------
// The item channel (item_valid, item_stall, item) carries one signed value per
// request; the request with is_last set closes the set. Up to 64 values are
// kept; further values are dropped and every result of that set then carries
// overflow. While a set is collected the item channel is not stalled.
// After the closing request the engine stalls the item channel and sorts by
// strand sort: each pass scans the pending memory, skipping taken entries,
// to pull a non-decreasing strand, then merges it with the sorted run one
// element at a time through a ping-pong merge memory. A strictly falling set
// has one strand per value. Results (result_valid, result_stall, result) then
// leave in ascending order, each read from the merge memory before it is
// loaded, the last one marked with final_res. A stalled result is held in
// the output register and the engine waits on it. Once the final result is
// loaded the item channel opens again for the next set.
// Reset (rst, synchronous) empties the set, clears the overflow mark and the
// taken marks, and drops any result not yet delivered.
// ----------------------------------------------------------------------------
module strand_sort_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  sse_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output sse_pkg::result_t result
);
  import sse_pkg::*;

  sse_cmd_t cmd;
  sse_sts_t sts;

  // The controller sequences the whole set; it sees the item handshake and status flags.
  sse_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_is_last (item.is_last),
    .sts          (sts),
    .cmd          (cmd),
    .item_stall   (item_stall)
  );

  // The datapath owns every memory, counter and the result register.
  sse_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .result_stall (result_stall),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result       (result)
  );

`ifndef SYNTHESIS
  // A value is stored only on an accepted request.
  a_store_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.store_in |-> (item_valid && !item_stall))
    else $error("store without an accepted request");

  // The set is closed out only together with its last result.
  a_finish_on_last: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (cmd.out_load && sts.out_last))
    else $error("set cleared before its last result");

  // A merge step never runs once both the run and the strand are used up.
  a_merge_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.merge_eval |-> !sts.merge_end)
    else $error("merge step past both inputs");

  // A loaded result is presented in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> result_valid)
    else $error("loaded result not presented");

  // The result register is only loaded when it is free.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result_valid || !result_stall))
    else $error("result overwritten while stalled");
`endif

endmodule

@@ hdl/sse_datapath.sv @@
// ----------------------------------------------------------------------------
// sse_datapath: storage, counters and compare logic of the strand sort engine
// Holds the pending, strand and merge memories, the taken marks, the index
// counters and the result register; acts on controller commands and result_stall.
// ----------------------------------------------------------------------------
module sse_datapath (
  input  logic              clk,
  input  logic              rst,
  input  sse_pkg::item_t    item,
  input  logic              result_stall,
  input  sse_pkg::sse_cmd_t cmd,
  output sse_pkg::sse_sts_t sts,
  output logic              result_valid,
  output sse_pkg::result_t  result
);
  import sse_pkg::*;

  logic [DATA_W-1:0] pend_mem   [MAX_ITEMS];
  logic [DATA_W-1:0] strand_mem [MAX_ITEMS];
  logic [DATA_W-1:0] merge_mem  [MRG_DEPTH];
  logic [DATA_W-1:0] pend_q;
  logic [DATA_W-1:0] strand_q;
  logic [DATA_W-1:0] merge_q;

  logic [MAX_ITEMS-1:0] taken;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [CNT_W-1:0]     remaining;
  logic [CNT_W-1:0]     scan;
  logic [CNT_W-1:0]     slen;
  logic [CNT_W-1:0]     mlen;
  logic [CNT_W-1:0]     mi;
  logic [CNT_W-1:0]     sj;
  logic [CNT_W-1:0]     mk;
  logic                 dropped;
  logic                 bank;
  logic                 full;
  logic signed [DATA_W-1:0] tail;
  logic                 take_sample;
  logic                 take_strand;
  logic [IDX_W:0]       merge_raddr;

  assign full        = (count == CNT_W'(MAX_ITEMS));
  assign count_next  = full ? count : count + CNT_W'(1);
  // A scanned value joins the strand when it opens it or does not fall below its tail.
  assign take_sample = (slen == '0) || !($signed(pend_q) < tail);
  // Ties go to the strand side, as do all values once the merged run is used up.
  assign take_strand = (sj != slen) &&
                       ((mi == mlen) || !($signed(merge_q) < $signed(strand_q)));
  assign merge_raddr = cmd.out_read ? {bank, mk[IDX_W-1:0]} : {bank, mi[IDX_W-1:0]};

  assign sts.scan_end       = (scan == count);
  assign sts.scan_taken     = taken[scan[IDX_W-1:0]];
  assign sts.remaining_zero = (remaining == '0);
  assign sts.merge_end      = (mi == mlen) && (sj == slen);
  assign sts.out_last       = ((mk + CNT_W'(1)) == count);
  assign sts.out_free       = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (cmd.store_in && !full) begin
      pend_mem[count[IDX_W-1:0]] <= item.sample;
    end
    if (cmd.scan_read) begin
      pend_q <= pend_mem[scan[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_eval && take_sample) begin
      strand_mem[slen[IDX_W-1:0]] <= pend_q;
    end
    if (cmd.merge_read) begin
      strand_q <= strand_mem[sj[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.merge_eval) begin
      merge_mem[{~bank, mk[IDX_W-1:0]}] <= take_strand ? strand_q : merge_q;
    end
    if (cmd.merge_read || cmd.out_read) begin
      merge_q <= merge_mem[merge_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_eval && take_sample) begin
      tail <= $signed(pend_q);
    end
    if (cmd.out_load) begin
      result.sorted_value <= $signed(merge_q);
      result.final_res    <= sts.out_last;
      result.overflow     <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      dropped      <= 1'b0;
      taken        <= '0;
      remaining    <= '0;
      scan         <= '0;
      slen         <= '0;
      mlen         <= '0;
      mi           <= '0;
      sj           <= '0;
      mk           <= '0;
      bank         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.store_in) begin
        count <= count_next;
        if (full) begin
          dropped <= 1'b1;
        end
      end
      if (cmd.sort_init) begin
        remaining <= count_next;
        mlen      <= '0;
        bank      <= 1'b0;
      end
      if (cmd.scan_init) begin
        scan <= '0;
        slen <= '0;
      end
      if (cmd.scan_skip) begin
        scan <= scan + CNT_W'(1);
      end
      if (cmd.scan_eval) begin
        scan <= scan + CNT_W'(1);
        if (take_sample) begin
          taken[scan[IDX_W-1:0]] <= 1'b1;
          slen                   <= slen + CNT_W'(1);
          remaining              <= remaining - CNT_W'(1);
        end
      end
      if (cmd.merge_init) begin
        mi <= '0;
        sj <= '0;
        mk <= '0;
      end
      if (cmd.merge_eval) begin
        mk <= mk + CNT_W'(1);
        if (take_strand) begin
          sj <= sj + CNT_W'(1);
        end else begin
          mi <= mi + CNT_W'(1);
        end
      end
      if (cmd.merge_done) begin
        mlen <= mk;
        bank <= ~bank;
      end
      if (cmd.out_init) begin
        mk <= '0;
      end
      if (cmd.out_load) begin
        mk           <= mk + CNT_W'(1);
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cmd.finish) begin
        count   <= '0;
        dropped <= 1'b0;
        taken   <= '0;
      end
    end
  end

endmodule

@@ hdl/sse_ctrl.sv @@
// ----------------------------------------------------------------------------
// sse_ctrl: sequencing state machine of the strand sort engine
// Steps through collection, strand extraction, merging and output, and
// issues one command group to the datapath in each cycle.
// ----------------------------------------------------------------------------
module sse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_is_last,
  input  sse_pkg::sse_sts_t sts,
  output sse_pkg::sse_cmd_t cmd,
  output logic              item_stall
);
  import sse_pkg::*;

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_SCAN_CHK   = 3'd1;
  localparam logic [2:0] ST_SCAN_EVAL  = 3'd2;
  localparam logic [2:0] ST_MERGE_RD   = 3'd3;
  localparam logic [2:0] ST_MERGE_EVAL = 3'd4;
  localparam logic [2:0] ST_OUT_RD     = 3'd5;
  localparam logic [2:0] ST_OUT_LOAD   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign item_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.store_in = 1'b1;
          if (item_is_last) begin
            cmd.sort_init = 1'b1;
            cmd.scan_init = 1'b1;
            state_next    = ST_SCAN_CHK;
          end
        end
      end
      ST_SCAN_CHK: begin
        if (sts.scan_end) begin
          cmd.merge_init = 1'b1;
          state_next     = ST_MERGE_RD;
        end else if (sts.scan_taken) begin
          cmd.scan_skip = 1'b1;
        end else begin
          cmd.scan_read = 1'b1;
          state_next    = ST_SCAN_EVAL;
        end
      end
      ST_SCAN_EVAL: begin
        cmd.scan_eval = 1'b1;
        state_next    = ST_SCAN_CHK;
      end
      ST_MERGE_RD: begin
        if (sts.merge_end) begin
          cmd.merge_done = 1'b1;
          if (sts.remaining_zero) begin
            cmd.out_init = 1'b1;
            state_next   = ST_OUT_RD;
          end else begin
            cmd.scan_init = 1'b1;
            state_next    = ST_SCAN_CHK;
          end
        end else begin
          cmd.merge_read = 1'b1;
          state_next     = ST_MERGE_EVAL;
        end
      end
      ST_MERGE_EVAL: begin
        cmd.merge_eval = 1'b1;
        state_next     = ST_MERGE_RD;
      end
      ST_OUT_RD: begin
        cmd.out_read = 1'b1;
        state_next   = ST_OUT_LOAD;
      end
      ST_OUT_LOAD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.out_last) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
